[rtl/core/pqed_pkg.sv]
// Package for the product-quantizer encode/distance unit.
// Holds widths, operation codes, state encodings and a helper function; no dependencies.
`default_nettype none
package pqed_pkg;
    localparam int unsigned CB_DEPTH  = 65536;
    localparam int unsigned CB_AW     = 16;
    localparam int unsigned BUF_DEPTH = 16;
    localparam int unsigned BUF_AW    = 4;
    localparam int unsigned VAL_W     = 16;
    localparam int unsigned SQ_W      = 34;
    localparam int unsigned SUM_W     = 41;
    localparam int unsigned DIST_W    = 20;
    localparam int unsigned ENC_W     = 38;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_DIST   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] REG_NUM_SUB  = 2'd0;
    localparam logic [1:0] REG_SUB_DIM  = 2'd1;
    localparam logic [1:0] REG_CODE_BITS = 2'd2;

    typedef enum logic [2:0] {
        t_ST_IDLE, t_ST_SEARCH, t_ST_DRAIN, t_ST_DIST, t_ST_SQRT, t_ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  subspace;
        logic [7:0]  codeword;
        logic [3:0]  position;
        logic signed [15:0] value;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [3:0]  result_subspace;
        logic [7:0]  code;
        logic [19:0] distance;
        logic        final_res;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [SUM_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [DIST_W-1:0] root;
    } t_sqrt_sts;

    function automatic logic [SQ_W-1:0] sq_diff(input logic signed [VAL_W-1:0] a,
                                                input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] d;
        logic [VAL_W:0]        m;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        m = d[VAL_W] ? (~d + 1'b1) : d;
        sq_diff = SQ_W'(m) * SQ_W'(m);
    endfunction
endpackage
`default_nettype wire

[rtl/core/pqed_stream_if.sv]
// Valid/ready channel interface for the product-quantizer unit.
// Depends on pqed_pkg only by the payload type given as parameter.
`default_nettype none
interface pqed_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/pqed_ram.sv]
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module pqed_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/core/pqed_isqrt.sv]
// Iterative integer square root, two radicand bits per cycle, saturated to DIST_W.
// Depends on pqed_pkg.
`default_nettype none
module pqed_isqrt (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pqed_pkg::t_sqrt_req  i_req,
    output pqed_pkg::t_sqrt_sts       o_sts
);
    import pqed_pkg::*;
    localparam int unsigned RW = SUM_W + 1;
    localparam int unsigned STEPS = RW / 2;
    localparam int unsigned QW = STEPS;

    logic [RW-1:0]     r_rem, n_rem;
    logic [QW-1:0]     r_root, n_root;
    logic [RW-1:0]     r_num, n_num;
    logic [4:0]        r_cnt, n_cnt;
    logic              r_busy, r_done;
    logic [RW+1:0]     trial, remsh;

    always_comb begin
        remsh = {r_rem, r_num[RW-1 -: 2]};
        trial = remsh - {r_root, 2'b01};
        n_num = {r_num[RW-3:0], 2'b00};
        n_cnt = r_cnt - 1'b1;
        if (!trial[RW+1]) begin
            n_rem  = trial[RW-1:0];
            n_root = {r_root[QW-2:0], 1'b1};
        end else begin
            n_rem  = remsh[RW-1:0];
            n_root = {r_root[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(STEPS);
            end else if (r_busy) begin
                r_cnt <= n_cnt;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_req.start && !r_busy) begin
            r_num  <= {1'b0, i_req.radicand};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.root = (|r_root[QW-1:DIST_W]) ? {DIST_W{1'b1}} : r_root[DIST_W-1:0];
endmodule
`default_nettype wire

[rtl/core/product_quantizer_encode_distance_unit.sv]
// Top level of the product-quantizer encode and asymmetric-distance unit.
// Depends on pqed_pkg, pqed_stream_if, pqed_ram and pqed_isqrt.
//
// Usage: input beats arrive on i_in (valid/ready). Operation write stores one
// codebook element into a 64K x 16 memory addressed by subspace, codeword and
// position. Encode buffers one element; at position sub_dim-1 it scans all
// 2^code_bits codewords of the subspace, one element read per cycle from the
// codebook memory, and emits one code beat on o_out. Distance adds one squared
// difference to a 41-bit saturating sum; with last set a 21-step iterative
// square root runs and one distance beat leaves.
// Flow: a write or a plain encode beat leaves the block idle; a distance beat
// without last passes through the distance state. A searching encode runs
// the search, drain and output states (memory read port bound, one element
// per cycle); a last distance beat shows its distance once the root is done.
// One item is worked on at a time; i_in is ready only in the idle state.
// The result sits in an output register; while the receiver stalls the
// block keeps it and, since the register is full, takes no new item.
// Reset (synchronous, active low) sets the registers to 8/8/8, clears the
// sum and the control state; memories are undefined until written.
`default_nettype none
module product_quantizer_encode_distance_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [4:0] i_cfg_data,
    pqed_stream_if.sink     i_in,
    pqed_stream_if.source   o_out
);
    import pqed_pkg::*;

    logic [4:0] r_num_sub, r_sub_dim;
    logic [3:0] r_code_bits;
    t_state     r_state, n_state;
    t_in_item   r_item;
    logic [SUM_W-1:0] r_sum;
    logic [ENC_W-1:0] r_acc, r_best;
    logic       r_have_best;
    logic [7:0] r_best_k, r_k, r_rd_k;
    logic [3:0] r_d, r_rd_d;
    logic       r_rd_v, r_rd_last;
    t_out_item  r_out;
    logic       r_out_v;

    logic [4:0] dim;
    logic [3:0] cbits;
    logic [4:0] nsub;
    logic [7:0] kmax;
    logic       accept;

    logic       cb_we;
    logic [CB_AW-1:0] cb_wa, cb_ra;
    logic [VAL_W-1:0] cb_rd, buf_rd;
    logic       buf_we;
    logic [BUF_AW-1:0] buf_ra;

    t_sqrt_req  sq_req;
    t_sqrt_sts  sq_sts;

    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] n_sum_val;

    always_comb begin
        dim   = (r_sub_dim == 5'd0) ? 5'd1 : ((r_sub_dim > 5'd16) ? 5'd16 : r_sub_dim);
        nsub  = (r_num_sub == 5'd0) ? 5'd1 : ((r_num_sub > 5'd16) ? 5'd16 : r_num_sub);
        cbits = (r_code_bits == 4'd0) ? 4'd1 : ((r_code_bits > 4'd8) ? 4'd8 : r_code_bits);
        kmax  = 8'((9'd1 << cbits) - 9'd1);
    end

    assign i_in.ready = (r_state == t_ST_IDLE) && !r_out_v;
    assign accept = i_in.valid && i_in.ready;

    // Codebook writes come straight from the accepted beat.
    assign cb_we = accept && (i_in.data.operation == OP_WRITE);
    assign cb_wa = {i_in.data.subspace, i_in.data.codeword, i_in.data.position};
    assign buf_we = accept && (i_in.data.operation == OP_ENCODE);

    // Outside the search the codebook is read at the offered beat's address, so a
    // distance beat finds its element on the read port in the cycle after it is taken.
    always_comb begin
        if (r_state == t_ST_SEARCH) begin
            cb_ra  = {r_item.subspace, r_k, r_d};
            buf_ra = r_d;
        end else begin
            cb_ra  = {i_in.data.subspace, i_in.data.codeword, i_in.data.position};
            buf_ra = r_item.position;
        end
    end

    pqed_ram #(.WIDTH(VAL_W), .DEPTH(CB_DEPTH)) u_cb (
        .i_clk(i_clk), .i_we(cb_we), .i_waddr(cb_wa), .i_wdata(i_in.data.value),
        .i_raddr(cb_ra), .o_rdata(cb_rd));

    pqed_ram #(.WIDTH(VAL_W), .DEPTH(BUF_DEPTH)) u_buf (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(i_in.data.position),
        .i_wdata(i_in.data.value), .i_raddr(buf_ra), .o_rdata(buf_rd));

    // Saturating update of the distance sum.
    always_comb begin
        sum_wide  = {1'b0, r_sum} + (SUM_W+1)'(sq_diff(r_item.value, cb_rd));
        n_sum_val = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    end

    assign sq_req.start    = (r_state == t_ST_DIST) && r_item.last;
    assign sq_req.radicand = n_sum_val;

    pqed_isqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sq_req), .o_sts(sq_sts));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_IDLE: begin
                if (accept && i_in.data.operation == OP_ENCODE
                        && {1'b0, i_in.data.position} == dim - 5'd1) begin
                    n_state = t_ST_SEARCH;
                end else if (accept && i_in.data.operation == OP_DIST) begin
                    n_state = t_ST_DIST;
                end
            end
            t_ST_SEARCH: begin
                if (r_k == kmax && {1'b0, r_d} == dim - 5'd1) n_state = t_ST_DRAIN;
            end
            t_ST_DRAIN: n_state = t_ST_OUT;
            t_ST_DIST:  n_state = r_item.last ? t_ST_SQRT : t_ST_IDLE;
            t_ST_SQRT:  if (sq_sts.done) n_state = t_ST_IDLE;
            t_ST_OUT:   n_state = t_ST_IDLE;
            default:    n_state = t_ST_IDLE;
        endcase
    end

    logic [ENC_W-1:0] acc_next;
    assign acc_next = (r_rd_d == 4'd0 ? '0 : r_acc) + ENC_W'(sq_diff(buf_rd, cb_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= t_ST_IDLE;
            r_num_sub   <= 5'd8;
            r_sub_dim   <= 5'd8;
            r_code_bits <= 4'd8;
            r_sum       <= '0;
            r_out_v     <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_NUM_SUB:   r_num_sub   <= i_cfg_data;
                    REG_SUB_DIM:   r_sub_dim   <= i_cfg_data;
                    REG_CODE_BITS: r_code_bits <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (o_out.valid && o_out.ready) r_out_v <= 1'b0;
            r_rd_v <= (r_state == t_ST_SEARCH);
            if (r_state == t_ST_DIST) begin
                r_sum <= r_item.last ? '0 : n_sum_val;
            end
            if (r_state == t_ST_SQRT && sq_sts.done) r_out_v <= 1'b1;
            if (r_state == t_ST_OUT) r_out_v <= 1'b1;
        end
        if (accept) r_item <= i_in.data;
        if (accept) begin
            r_k <= '0;
            r_d <= '0;
            r_have_best <= 1'b0;
        end else if (r_state == t_ST_SEARCH) begin
            if ({1'b0, r_d} == dim - 5'd1) begin
                r_d <= '0;
                r_k <= r_k + 8'd1;
            end else begin
                r_d <= r_d + 4'd1;
            end
        end
        r_rd_k    <= r_k;
        r_rd_d    <= r_d;
        r_rd_last <= ({1'b0, r_d} == dim - 5'd1);
        // Compare each finished codeword sum; strict less keeps the lowest index on ties.
        if (r_rd_v) begin
            r_acc <= acc_next;
            if (r_rd_last && (!r_have_best || acc_next < r_best)) begin
                r_best      <= acc_next;
                r_best_k    <= r_rd_k;
                r_have_best <= 1'b1;
            end
        end
        if (r_state == t_ST_SQRT && sq_sts.done) begin
            r_out.kind            <= 1'b1;
            r_out.result_subspace <= '0;
            r_out.code            <= '0;
            r_out.distance        <= sq_sts.root;
            r_out.final_res       <= 1'b1;
        end
        if (r_state == t_ST_OUT) begin
            r_out.kind            <= 1'b0;
            r_out.result_subspace <= r_item.subspace;
            r_out.code            <= r_best_k;
            r_out.distance        <= '0;
            r_out.final_res       <= ({1'b0, r_item.subspace} == nsub - 5'd1);
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;
endmodule
`default_nettype wire

[rtl/core/pqed_checker.sv]
// Port-level checker for the product-quantizer unit, bound to the top level.
// No dependencies beyond the top-level module that it binds to.
`default_nettype none
module pqed_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic o_out_valid,
    input wire logic o_out_ready,
    input wire logic o_kind,
    input wire logic o_final,
    input wire logic [19:0] o_dist
);
    a_no_accept_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !i_in_ready) else $error("input ready while result pending");
    a_dist_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind) |-> o_final) else $error("distance result not final");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_ready) |=> o_out_valid && $stable(o_dist))
        else $error("stalled result changed");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("result after reset");
endmodule

bind product_quantizer_encode_distance_unit pqed_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .o_out_valid(o_out.valid), .o_out_ready(o_out.ready),
    .o_kind(o_out.data.kind), .o_final(o_out.data.final_res),
    .o_dist(o_out.data.distance));
`default_nettype wire

[sim/pqed_scoreboard.sv]
// Scoreboard class for the product-quantizer encode/distance unit testbench.
// Depends on pqed_pkg; holds the predictor of codes and distances and the queue of expected beats.
`default_nettype none
class pqed_scoreboard;
    logic signed [15:0] codebook_mem [int];
    logic signed [15:0] subvec [16];
    logic [40:0]        dist_acc;
    logic [4:0]         reg_nsub, reg_dim, reg_cbits;
    pqed_pkg::t_out_item pending_q [$];
    int                 err_count;

    function void reset_model();
        codebook_mem.delete();
        dist_acc  = '0;
        reg_nsub  = 5'd8;
        reg_dim   = 5'd8;
        reg_cbits = 5'd8;
        pending_q.delete();
        err_count = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [4:0] data);
        if (idx == pqed_pkg::REG_NUM_SUB) reg_nsub = data;
        else if (idx == pqed_pkg::REG_SUB_DIM) reg_dim = data;
        else if (idx == pqed_pkg::REG_CODE_BITS) reg_cbits = {1'b0, data[3:0]};
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function logic signed [15:0] cb_get(int s, int k, int d);
        int key;
        key = (s * 256 + k) * 16 + d;
        return codebook_mem.exists(key) ? codebook_mem[key] : 16'sd0;
    endfunction

    function longint unsigned sqd(logic signed [15:0] a, logic signed [15:0] b);
        longint m;
        m = longint'(a) - longint'(b);
        if (m < 0) m = -m;
        return longint'(m * m);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Append one expected beat behind the ones already waiting.
    function void expect_beat(pqed_pkg::t_out_item r);
        pending_q.insert(pending_q.size(), r);
    endfunction

    // Note an accepted input beat and queue any result it causes.
    function void note_input(pqed_pkg::t_in_item it);
        int unsigned ns, dim, ncw;
        longint unsigned best, acc, lim;
        int best_k;
        pqed_pkg::t_out_item r;
        ns  = clamp(reg_nsub, 16);
        dim = clamp(reg_dim, 16);
        ncw = 1 << clamp(reg_cbits, 8);
        r = '0;
        lim = (64'd1 << 41) - 1;
        if (it.operation == pqed_pkg::OP_WRITE) begin
            codebook_mem[(it.subspace * 256 + it.codeword) * 16 + it.position] = it.value;
        end else if (it.operation == pqed_pkg::OP_ENCODE) begin
            subvec[it.position] = it.value;
            if (it.position == dim - 1) begin
                best = '1;
                best_k = 0;
                for (int k = 0; k < ncw; k++) begin
                    acc = 0;
                    for (int d = 0; d < dim; d++)
                        acc += sqd(subvec[d], cb_get(it.subspace, k, d));
                    if (acc < best) begin
                        best = acc;
                        best_k = k;
                    end
                end
                r.kind = 1'b0;
                r.result_subspace = it.subspace;
                r.code = best_k[7:0];
                r.final_res = (it.subspace == ns - 1);
                expect_beat(r);
            end
        end else if (it.operation == pqed_pkg::OP_DIST) begin
            acc = dist_acc + sqd(it.value, cb_get(it.subspace, it.codeword, it.position));
            dist_acc = (acc > lim) ? lim[40:0] : acc[40:0];
            if (it.last) begin
                acc = floor_sqrt(dist_acc);
                if (acc > 64'hFFFFF) acc = 64'hFFFFF;
                r.kind = 1'b1;
                r.distance = acc[19:0];
                r.final_res = 1'b1;
                dist_acc = '0;
                expect_beat(r);
            end
        end
    endfunction

    function void report(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        err_count++;
    endfunction

    // Compare one accepted output beat against the oldest expectation.
    function void check_result(pqed_pkg::t_out_item got);
        pqed_pkg::t_out_item want;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected beat %p", got));
            return;
        end
        want = pending_q.pop_front();
        if (got.kind !== want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
        if (got.result_subspace !== want.result_subspace)
            report($sformatf("subspace %0d want %0d", got.result_subspace, want.result_subspace));
        if (got.code !== want.code) report($sformatf("code %0d want %0d", got.code, want.code));
        if (got.distance !== want.distance)
            report($sformatf("distance %0d want %0d", got.distance, want.distance));
        if (got.final_res !== want.final_res)
            report($sformatf("final %0d want %0d", got.final_res, want.final_res));
    endfunction
endclass
`default_nettype wire

[sim/product_quantizer_encode_distance_unit_tb.sv]
// Testbench top for product_quantizer_encode_distance_unit.
// Depends on pqed_pkg, pqed_stream_if, the RTL and pqed_scoreboard.
`default_nettype none
module product_quantizer_encode_distance_unit_tb;
    import pqed_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [4:0] i_cfg_data = '0;

    pqed_stream_if #(.T(t_in_item))  in_ch();
    pqed_stream_if #(.T(t_out_item)) out_ch();

    product_quantizer_encode_distance_unit DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    pqed_scoreboard sb;

    // Idle percentages for the two sides; zero gives a stretch at full rate.
    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 35;
    bit          hold_off = 1'b0;

    // Current register settings, so that reads only touch written entries.
    int unsigned cfg_dim = 8, cfg_cb = 8;

    // Number of input beats taken so far.
    int unsigned beats = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Receiver: ready is changed at falling edges, beats taken at rising edges.
    always @(negedge i_clk) begin
        if (hold_off) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end

    // Offer one beat and hold it until the block takes it. Valid stays high after
    // the beat so that a following beat can go out back to back.
    task automatic send_beat(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(it);
        beats++;
        @(negedge i_clk);
    endtask

    // Stop offering, then wait for every expected beat plus a margin.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [4:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(int unsigned ns, int unsigned dim, int unsigned cb);
        drain();
        write_cfg(REG_NUM_SUB, ns[4:0]);
        write_cfg(REG_SUB_DIM, dim[4:0]);
        write_cfg(REG_CODE_BITS, cb[4:0]);
        i_cfg_we <= 1'b0;
        cfg_dim = dim;
        cfg_cb = cb;
    endtask

    function automatic t_in_item mk(logic [1:0] op, int s, int k, int p, int v, bit l);
        t_in_item it;
        it.operation = op;
        it.subspace = s[3:0];
        it.codeword = k[7:0];
        it.position = p[3:0];
        it.value = v[15:0];
        it.last = l;
        return it;
    endfunction

    function automatic int rval();
        case ($urandom_range(3))
            0: return $urandom_range(3) == 0 ? -32768 : 32767;
            1: return int'($urandom_range(511)) - 256;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // Fill every codeword of one subspace that the current code_bits can search.
    task automatic fill_subspace(int s);
        for (int k = 0; k < (1 << cfg_cb); k++)
            for (int p = 0; p < cfg_dim; p++)
                send_beat(mk(OP_WRITE, s, k, p, rval(), $urandom_range(1)));
    endtask

    // A full subvector encode: all positions, the last one triggers the search.
    task automatic encode_vec(int s);
        for (int p = 0; p < cfg_dim; p++) send_beat(mk(OP_ENCODE, s, $urandom_range(255), p,
                                                      rval(), $urandom_range(1)));
    endtask

    // A distance run over written entries of subspace s, codeword k.
    task automatic distance_run(int s, int k, int n);
        for (int i = 0; i < n; i++)
            send_beat(mk(OP_DIST, s, k, $urandom_range(cfg_dim - 1), rval(), i == n - 1));
    endtask

    int unsigned s_pick;
    bit          filled [16];

    initial begin
        sb = new();
        sb.reset_model();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with small sizes: extremes, every operation and special cases.
        set_config(16, 2, 1);
        send_beat(mk(OP_WRITE, 15, 0, 0, -32768, 0));
        send_beat(mk(OP_WRITE, 15, 0, 1, 32767, 1));
        send_beat(mk(OP_WRITE, 15, 1, 0, 32767, 0));
        send_beat(mk(OP_WRITE, 15, 1, 1, -32768, 0));
        send_beat(mk(OP_ENCODE, 15, 0, 0, 32767, 0));
        send_beat(mk(OP_ENCODE, 15, 0, 1, -32768, 0));   // search, final subspace
        send_beat(mk(OP_ENCODE, 15, 0, 0, 0, 0));
        send_beat(mk(OP_ENCODE, 15, 0, 1, 0, 0));        // tie goes to index zero
        send_beat(mk(OP_ENCODE, 15, 0, 5, 0, 1));        // past sub_dim: no search
        send_beat(mk(OP_UNUSED, 15, 255, 15, -1, 1));    // unknown operation ignored
        send_beat(mk(OP_DIST, 15, 0, 0, 32767, 0));
        send_beat(mk(OP_DIST, 15, 1, 1, 32767, 0));
        send_beat(mk(OP_DIST, 15, 0, 1, -32768, 1));     // large sum
        send_beat(mk(OP_DIST, 15, 1, 0, 32767, 1));      // exact zero distance
        // Repeated maximal differences on one sum; eight of them stay below the 41-bit limit.
        for (int i = 0; i < 8; i++) send_beat(mk(OP_DIST, 15, 0, 0, 32767, i == 7));
        set_config(1, 1, 1);                             // subspace beyond count: not final
        send_beat(mk(OP_WRITE, 3, 0, 0, 100, 0));
        send_beat(mk(OP_WRITE, 3, 1, 0, -100, 0));
        send_beat(mk(OP_ENCODE, 3, 0, 0, -90, 0));
        set_config(0, 0, 0);                             // zero registers act as one
        send_beat(mk(OP_ENCODE, 3, 0, 0, 90, 0));

        // Random part: phases over several settings, mostly well-formed sequences.
        for (int phase = 0; beats < 900; phase++) begin
            case (phase % 5)
                0: set_config(4, 4, 2);
                1: set_config(16, 16, 1);
                2: set_config(31, 3, 3);
                3: set_config(8, 1, 8);
                default: set_config($urandom_range(1, 16), $urandom_range(1, 6),
                                     $urandom_range(1, 4));
            endcase
            send_idle_pct = (phase == 2) ? 0 : 35;
            recv_idle_pct = (phase == 2) ? 0 : 35;
            foreach (filled[i]) filled[i] = 1'b0;
            for (int rep = 0; rep < (cfg_cb == 8 ? 1 : 3); rep++) begin
                s_pick = $urandom_range(15);
                if (!filled[s_pick]) begin
                    fill_subspace(s_pick);
                    filled[s_pick] = 1'b1;
                end
                for (int j = 0; j < (cfg_cb == 8 ? 2 : 6); j++) begin
                    case ($urandom_range(9))
                        0: begin
                            send_beat(mk(OP_UNUSED, $urandom_range(15), $urandom_range(255),
                                         $urandom_range(15), rval(), $urandom_range(1)));
                        end
                        1, 2, 3, 4: begin
                            encode_vec(s_pick);
                        end
                        default: begin
                            distance_run(s_pick, $urandom_range((1 << cfg_cb) - 1),
                                         $urandom_range(1, 6));
                        end
                    endcase
                end
            end
            // Long receiver hold-off while the sender keeps offering beats.
            if (phase == 1) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                    begin
                        for (int j = 0; j < 4; j++) encode_vec(s_pick);
                        distance_run(s_pick, 0, 3);
                    end
                join
            end
        end
        drain();
        if (sb.err_count == 0 && sb.pending_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
